@@ sv/x86d_pkg.sv @@
// Package: shared types and constants for the x86 field decoder.
package x86d_pkg;

    typedef enum logic [1:0] {
        OP_MOV = 2'd0,
        OP_ADD = 2'd1,
        OP_SUB = 2'd2,
        OP_CMP = 2'd3
    } oper_t;

    typedef enum logic [2:0] {
        FORM_RM_REG  = 3'd0,
        FORM_IMM_REG = 3'd1,
        FORM_IMM_RM  = 3'd2,
        FORM_ACC_MEM = 3'd3,
        FORM_IMM_ACC = 3'd4
    } form_t;

    // Finished instruction as handed from front to back
    typedef struct packed {
        logic        unsup;
        logic [1:0]  oper;
        logic [2:0]  form;
        logic [7:0]  opcode;
        logic [7:0]  modrm;
        logic [15:0] disp;
        logic [15:0] imm;
        logic [1:0]  dlen;
        logic [1:0]  ilen;
        logic [2:0]  length;
    } instr_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  form;
        logic        to_register;
        logic        wide;
        logic [1:0]  mode;
        logic [2:0]  reg_number;
        logic [2:0]  rm_number;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [2:0]  length;
        logic        unsupported;
    } result_t;

    localparam int QUEUE_DEPTH = 2;

    function automatic logic [1:0] modrm_disp_len(input logic [7:0] m);
        logic [1:0] r;
        r = 2'd0;
        if (m[7:6] == 2'd1) r = 2'd1;
        else if (m[7:6] == 2'd2) r = 2'd2;
        else if (m[7:6] == 2'd0 && m[2:0] == 3'd6) r = 2'd2;
        return r;
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

endpackage

@@ sv/x86d_byte_if.sv @@
// Interface: code byte channel.
interface x86d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    modport source (output valid, output code_byte, input ready);
    modport sink (input valid, input code_byte, output ready);
endinterface

@@ sv/x86d_result_if.sv @@
// Interface: decoded result channel.
interface x86d_result_if;
    logic                 valid;
    logic                 ready;
    x86d_pkg::result_t    result;
    modport source (output valid, output result, input ready);
    modport sink (input valid, input result, output ready);
endinterface

@@ sv/x86d_front.sv @@
// Front end: collects bytes of one instruction and classifies it.
module x86d_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    output logic                push,
    output x86d_pkg::instr_t    push_data,
    input  logic                q_full
);
    logic              busy_reg, busy_next;
    logic [7:0]        op_reg, op_next;
    logic [7:0]        modrm_reg, modrm_next;
    logic [15:0]       disp_reg, disp_next;
    logic [15:0]       imm_reg, imm_next;
    logic [2:0]        seen_reg, seen_next;
    logic [7:0]        op;
    logic [7:0]        m;
    logic [2:0]        p;
    logic              unsup;
    logic [1:0]        oper;
    logic [2:0]        form;
    logic              hm;
    logic [1:0]        dl;
    logic [1:0]        il;
    logic              s_bit;
    logic [2:0]        q;
    logic [2:0]        total;
    logic              fire;
    logic              done;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;
    assign op       = busy_reg ? op_reg : in_byte;
    assign p        = busy_reg ? seen_reg : 3'd0;

    // Opcode classification, first match wins
    always_comb
    begin
        unsup = 1'b0;
        oper  = x86d_pkg::OP_MOV;
        form  = x86d_pkg::FORM_RM_REG;
        priority if (op[7:1] == 7'h02) begin oper = x86d_pkg::OP_ADD; form = x86d_pkg::FORM_IMM_ACC; end
        else if (op[7:1] == 7'h16) begin oper = x86d_pkg::OP_SUB; form = x86d_pkg::FORM_IMM_ACC; end
        else if (op[7:1] == 7'h1E) begin oper = x86d_pkg::OP_CMP; form = x86d_pkg::FORM_IMM_ACC; end
        else if (op[7:2] == 6'h22) begin oper = x86d_pkg::OP_MOV; form = x86d_pkg::FORM_RM_REG; end
        else if (op[7:2] == 6'h00) begin oper = x86d_pkg::OP_ADD; form = x86d_pkg::FORM_RM_REG; end
        else if (op[7:2] == 6'h0A) begin oper = x86d_pkg::OP_SUB; form = x86d_pkg::FORM_RM_REG; end
        else if (op[7:2] == 6'h0E) begin oper = x86d_pkg::OP_CMP; form = x86d_pkg::FORM_RM_REG; end
        else if (op[7:2] == 6'h20) begin oper = x86d_pkg::OP_ADD; form = x86d_pkg::FORM_IMM_RM; end
        else if (op[7:4] == 4'hB) form = x86d_pkg::FORM_IMM_REG;
        else if (op[7:4] == 4'hC) form = x86d_pkg::FORM_IMM_RM;
        else if (op[7:4] == 4'hA) form = x86d_pkg::FORM_ACC_MEM;
        else unsup = 1'b1;
    end

    // Byte capture; ModRM used for layout is the one seen so far or this beat
    always_comb
    begin
        modrm_next = busy_reg ? modrm_reg : 8'd0;
        disp_next  = busy_reg ? disp_reg : 16'd0;
        imm_next   = busy_reg ? imm_reg : 16'd0;
        hm = (form == x86d_pkg::FORM_RM_REG) || (form == x86d_pkg::FORM_IMM_RM);
        if (p == 3'd1 && hm) modrm_next = in_byte;
        m  = modrm_next;
        s_bit = (op[7:2] == 6'h20) ? op[1] : 1'b0;
        dl = 2'd0;
        il = 2'd0;
        unique case (form)
            x86d_pkg::FORM_RM_REG:  dl = x86d_pkg::modrm_disp_len(m);
            x86d_pkg::FORM_IMM_REG: il = op[3] ? 2'd2 : 2'd1;
            x86d_pkg::FORM_IMM_RM:
            begin
                dl = x86d_pkg::modrm_disp_len(m);
                il = (op[0] && !s_bit) ? 2'd2 : 2'd1;
            end
            x86d_pkg::FORM_ACC_MEM: dl = 2'd2;
            default:                il = op[0] ? 2'd2 : 2'd1;
        endcase
        q = p - 3'd1 - {2'd0, hm};
        if (p >= 3'd1 && !(p == 3'd1 && hm))
        begin
            if (q < {1'b0, dl})
            begin
                if (q == 3'd0) disp_next = {8'd0, in_byte};
                else disp_next = {in_byte, disp_next[7:0]};
            end
            else
            begin
                if (q == {1'b0, dl}) imm_next = {8'd0, in_byte};
                else imm_next = {in_byte, imm_next[7:0]};
            end
        end
        total = 3'd1 + {2'd0, hm} + {1'b0, dl} + {1'b0, il};
        done  = unsup || (p + 3'd1 >= total);
        op_next   = op;
        busy_next = !done;
        seen_next = done ? 3'd0 : p + 3'd1;
    end

    always_comb
    begin
        push              = fire && done;
        push_data.unsup   = unsup;
        push_data.oper    = oper;
        push_data.form    = form;
        push_data.opcode  = op;
        push_data.modrm   = m;
        push_data.disp    = disp_next;
        push_data.imm     = imm_next;
        push_data.dlen    = dl;
        push_data.ilen    = il;
        push_data.length  = unsup ? 3'd1 : total;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            seen_reg <= 3'd0;
        end
        else if (fire)
        begin
            busy_reg <= busy_next;
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            op_reg    <= op_next;
            modrm_reg <= modrm_next;
            disp_reg  <= disp_next;
            imm_reg   <= imm_next;
        end
    end
endmodule

@@ sv/x86d_queue.sv @@
// Short FIFO between front and back.
module x86d_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  x86d_pkg::instr_t  push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output x86d_pkg::instr_t  pop_data
);
    localparam int AW = $clog2(x86d_pkg::QUEUE_DEPTH);
    x86d_pkg::instr_t mem_reg [x86d_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;

    assign full      = cnt_reg == (AW+1)'(x86d_pkg::QUEUE_DEPTH);
    assign not_empty = cnt_reg != '0;
    assign pop_data  = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_data;
    end
endmodule

@@ sv/x86d_back.sv @@
// Back end: forms result fields and holds them in the output register.
module x86d_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              pop,
    input  x86d_pkg::instr_t  q_data,
    output logic              out_valid,
    input  logic              out_ready,
    output x86d_pkg::result_t out_result
);
    logic              valid_reg;
    x86d_pkg::result_t res_reg, res_next;
    logic [7:0]        op;
    logic [7:0]        m;

    assign pop        = q_valid && (!valid_reg || out_ready);
    assign out_valid  = valid_reg;
    assign out_result = res_reg;
    assign op         = q_data.opcode;
    assign m          = q_data.modrm;

    // Field formation
    always_comb
    begin
        res_next              = '0;
        res_next.operation    = q_data.oper;
        res_next.form         = q_data.form;
        res_next.wide         = op[0];
        res_next.mode         = 2'd3;
        res_next.displacement = (q_data.dlen == 2'd1) ? x86d_pkg::sext8(q_data.disp[7:0])
                                                      : q_data.disp;
        res_next.immediate    = q_data.imm;
        if (q_data.ilen == 2'd1)
            res_next.immediate = (q_data.form == x86d_pkg::FORM_IMM_REG)
                                 ? {8'd0, q_data.imm[7:0]} : x86d_pkg::sext8(q_data.imm[7:0]);
        res_next.length = q_data.length;
        unique case (q_data.form)
            x86d_pkg::FORM_RM_REG:
            begin
                res_next.to_register = op[1];
                res_next.mode        = m[7:6];
                res_next.reg_number  = m[5:3];
                res_next.rm_number   = m[2:0];
            end
            x86d_pkg::FORM_IMM_REG:
            begin
                res_next.to_register = 1'b1;
                res_next.wide        = op[3];
                res_next.reg_number  = op[2:0];
            end
            x86d_pkg::FORM_IMM_RM:
            begin
                res_next.mode       = m[7:6];
                res_next.reg_number = m[5:3];
                res_next.rm_number  = m[2:0];
                if (op[7:2] == 6'h20)
                    res_next.operation = (m[5:3] == 3'd0) ? x86d_pkg::OP_ADD :
                                         (m[5:3] == 3'd7) ? x86d_pkg::OP_CMP : x86d_pkg::OP_SUB;
            end
            x86d_pkg::FORM_ACC_MEM: res_next.to_register = !op[1];
            default:                res_next.to_register = 1'b1;
        endcase
        if (q_data.unsup)
        begin
            res_next             = '0;
            res_next.length      = 3'd1;
            res_next.unsupported = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (pop) valid_reg <= 1'b1;
        else if (out_ready) valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop) res_reg <= res_next;
    end
endmodule

@@ sv/x86_16bit_instruction_field_decoder_core.sv @@
// Top level: x86 16-bit instruction field decoder.
// Takes one code byte per beat and emits one result per finished mov/add/sub/cmp
// instruction (or per unknown opcode byte, flagged unsupported). A byte is accepted
// every cycle while the two-entry queue between the byte collector and the result
// stage has room. With the output flowing, the queue never holds more than one
// entry and input never stalls. A stalled output fills the result register and
// then the queue, and in_ch.ready drops once two finished instructions wait.
// The last byte of an instruction is written into the queue, and the result register
// loads from the queue when it holds no result or out_ch.ready is high.
module x86_16bit_instruction_field_decoder_core (
    input  logic          clk,
    input  logic          rst_n,
    x86d_byte_if.sink     in_ch,
    x86d_result_if.source out_ch
);
    logic             push, full, pop, not_empty;
    x86d_pkg::instr_t push_data, pop_data;

    x86d_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_byte(in_ch.code_byte),
        .push(push), .push_data(push_data), .q_full(full)
    );

    x86d_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_data(push_data), .full(full),
        .pop(pop), .not_empty(not_empty), .pop_data(pop_data)
    );

    x86d_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(not_empty), .pop(pop), .q_data(pop_data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_result(out_ch.result)
    );
endmodule

@@ sv/x86d_checker.sv @@
// Checker: port-level properties of the decoder, bound to the top level.
module x86d_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input x86d_pkg::result_t result
);
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result.length != 3'd0 && result.length != 3'd7)) else $error("bad length");
    a_unsup_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result.unsupported) |-> result.length == 3'd1) else $error("unsup length");
    a_form_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result.form <= 3'd4) else $error("bad form");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(result))) else $error("hold");
endmodule

bind x86_16bit_instruction_field_decoder_core x86d_checker u_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid),
    .out_ready(out_ch.ready), .result(out_ch.result)
);
